FILE: rtl/assert_macros.svh
// Assertion macros used by the evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Check that an antecedent implies a consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: rtl/ise_pkg.sv
// Package with payload types, operator codes and helpers for the evaluator.
package ise_pkg;
   localparam int NumDepth = 32;
   localparam int OprDepth = 32;
   localparam int NumAw = $clog2(NumDepth);
   localparam int OprAw = $clog2(OprDepth);
   localparam int CntW = 6;

   typedef enum logic [1:0] {
      CMD_PUSH = 2'd0,
      CMD_OFFER = 2'd1,
      CMD_FLUSH = 2'd2,
      CMD_NOP = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      OP_PLUS = 3'd0,
      OP_MINUS = 3'd1,
      OP_TIMES = 3'd2,
      OP_DIV = 3'd3,
      OP_MOD = 3'd4,
      OP_POW = 3'd5,
      OP_OPEN = 3'd6,
      OP_CLOSE = 3'd7
   } opc_type;

   typedef enum logic [2:0] {
      ERR_NONE = 3'd0,
      ERR_FEW = 3'd1,
      ERR_DIV0 = 3'd2,
      ERR_OVF = 3'd3,
      ERR_NEGEXP = 3'd4
   } err_type;

   typedef struct packed {
      logic [1:0] command;
      logic signed [31:0] number_value;
      logic [2:0] operator_code;
   } req_type;

   typedef struct packed {
      logic signed [31:0] top_value;
      logic [5:0] number_depth;
      logic [5:0] operator_depth;
      logic [2:0] error_code;
   } rsp_type;

   // Handshake between sequencer and arithmetic unit.
   typedef struct packed {
      logic start;
      logic [2:0] op;
   } alu_ctl_type;

   typedef struct packed {
      logic done;
      logic [2:0] err;
   } alu_sts_type;

   function automatic logic [2:0] prio(input logic [2:0] op);
      logic [2:0] p;
      case (op)
         OP_PLUS, OP_MINUS: p = 3'd2;
         OP_TIMES, OP_DIV, OP_MOD: p = 3'd3;
         OP_POW: p = 3'd4;
         OP_OPEN: p = 3'd5;
         default: p = 3'd1;
      endcase
      return p;
   endfunction
endpackage

FILE: rtl/ise_alu.sv
// Multi-cycle arithmetic unit: add, subtract, multiply, divide, modulo, power.
module ise_alu import ise_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  alu_ctl_type ctl,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output alu_sts_type sts,
   output logic [31:0] res
);
   typedef enum logic [1:0] {S_IDLE, S_DIV, S_POW, S_DONE} st_type;

   st_type      st_ff, st_in;
   logic [2:0]  op_ff, op_in;
   logic [2:0]  err_ff, err_in;
   logic [31:0] res_ff, res_in;
   // divider: remainder, quotient, divisor magnitude, signs
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        qneg_ff, qneg_in, rneg_ff, rneg_in;
   // power: base squared and exponent shifted per step
   logic [31:0] base_ff, base_in;
   logic [31:0] exp_ff, exp_in;
   logic        half_ff, half_in;

   logic [31:0] mag_a, mag_b, prod, mul_x, mul_y;
   logic [32:0] trial;

   assign mag_a = a[31] ? (~a + 32'd1) : a;
   assign mag_b = b[31] ? (~b + 32'd1) : b;
   // one shared 32x32 multiplier
   assign prod = mul_x * mul_y;
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};

   always_comb begin
      mul_x = a;
      mul_y = b;
      if (st_ff == S_POW) begin
         mul_x = half_ff ? base_ff : res_ff;
         mul_y = base_ff;
      end
   end

   always_comb begin
      st_in = st_ff;
      op_in = op_ff;
      err_in = err_ff;
      res_in = res_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      base_in = base_ff;
      exp_in = exp_ff;
      half_in = half_ff;
      case (st_ff)
         S_IDLE: begin
            if (ctl.start) begin
               op_in = ctl.op;
               err_in = ERR_NONE;
               st_in = S_DONE;
               case (ctl.op)
                  OP_PLUS: res_in = a + b;
                  OP_MINUS: res_in = a - b;
                  OP_TIMES: res_in = prod;
                  OP_DIV, OP_MOD: begin
                     if (b == 32'd0) begin
                        res_in = 32'd0;
                        err_in = ERR_DIV0;
                     end else begin
                        rem_in = 32'd0;
                        quo_in = mag_a;
                        dvs_in = mag_b;
                        cnt_in = 6'd0;
                        qneg_in = a[31] ^ b[31];
                        rneg_in = a[31];
                        st_in = S_DIV;
                     end
                  end
                  OP_POW: begin
                     if (b[31]) begin
                        res_in = 32'd0;
                        err_in = ERR_NEGEXP;
                     end else begin
                        res_in = 32'd1;
                        base_in = a;
                        exp_in = b;
                        half_in = 1'b0;
                        st_in = S_POW;
                     end
                  end
                  default: res_in = 32'd0;
               endcase
            end
         end
         S_DIV: begin
            // one restoring step a cycle
            if (!trial[32]) begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], quo_ff[31]};
               quo_in = {quo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) st_in = S_DONE;
         end
         S_POW: begin
            // alternate: multiply into acc when exponent bit 0 is set, then square base
            if (exp_ff == 32'd0) begin
               st_in = S_DONE;
            end else if (!half_ff) begin
               if (exp_ff[0]) res_in = prod;
               half_in = 1'b1;
            end else begin
               base_in = prod;
               exp_in = exp_ff >> 1;
               half_in = 1'b0;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         st_ff <= st_in;
      end
      op_ff <= op_in;
      err_ff <= err_in;
      res_ff <= res_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
      base_ff <= base_in;
      exp_ff <= exp_in;
      half_ff <= half_in;
   end

   logic [31:0] q_s, r_s;
   assign q_s = qneg_ff ? (~quo_ff + 32'd1) : quo_ff;
   assign r_s = rneg_ff ? (~rem_ff + 32'd1) : rem_ff;

   always_comb begin
      res = res_ff;
      if (op_ff == OP_DIV && err_ff == ERR_NONE) res = q_s;
      if (op_ff == OP_MOD && err_ff == ERR_NONE) res = r_s;
   end
   assign sts.done = (st_ff == S_DONE);
   assign sts.err = err_ff;
endmodule

FILE: rtl/infix_stack_evaluator.sv
// Steps: a push goes through S_TOP and S_OUT to the result strobe; offer/flush go through S_RD and
// S_DEC, reduce in S_ALU and S_WB (add, subtract, multiply, divide/modulo, power), then S_TOP and S_OUT.
// Throughput: one item at a time; busy covers the strobe cycle, so the next item follows it.
// Synchronous active-high reset empties both stacks; contents are not cleared.
// The receiver cannot stall: each result shows for one cycle on rsp_valid.
module infix_stack_evaluator import ise_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
`include "assert_macros.svh"

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_DEC, S_ALU, S_WB, S_TOP, S_OUT
   } st_type;

   st_type      st_ff, st_in;
   logic [CntW-1:0] ncnt_ff, ncnt_in, ocnt_ff, ocnt_in;
   logic [2:0]  err_ff, err_in;
   logic        flush_ff, flush_in;
   logic [2:0]  opin_ff, opin_in;
   logic [2:0]  topop_ff, topop_in;
   logic [31:0] ra_ff, ra_in, rb_ff, rb_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic [31:0] nmem [NumDepth];
   logic [2:0]  omem [OprDepth];
   logic [31:0] nrd_ff;
   logic [2:0]  ord_ff;

   // memory ports
   logic        nwe, owe;
   logic [NumAw-1:0] nwa, nra;
   logic [OprAw-1:0] owa, ora;
   logic [31:0] nwd;
   logic [2:0]  owd;

   alu_ctl_type actl;
   alu_sts_type asts;
   logic [31:0] ares;

   ise_alu u_alu (
      .clock(clock), .reset(reset), .ctl(actl), .a(ra_ff), .b(rb_ff),
      .sts(asts), .res(ares)
   );

   always_ff @(posedge clock) begin
      if (nwe) nmem[nwa] <= nwd;
      nrd_ff <= nmem[nra];
      if (owe) omem[owa] <= owd;
      ord_ff <= omem[ora];
   end

   logic [CntW-1:0] nm1, nm2, om1;
   assign nm1 = ncnt_ff - CntW'(1);
   assign nm2 = ncnt_ff - CntW'(2);
   assign om1 = ocnt_ff - CntW'(1);

   function automatic logic [2:0] first_err(input logic [2:0] cur, input logic [2:0] nw);
      return (cur == ERR_NONE) ? nw : cur;
   endfunction

   // Read sequence in S_RD: cycle A reads op top; ALU uses two reads, staged via sub-phase.
   logic [1:0] ph_ff, ph_in;

   always_comb begin
      st_in = st_ff;
      ncnt_in = ncnt_ff;
      ocnt_in = ocnt_ff;
      err_in = err_ff;
      flush_in = flush_ff;
      opin_in = opin_ff;
      topop_in = topop_ff;
      ra_in = ra_ff;
      rb_in = rb_ff;
      ph_in = ph_ff;
      rsp_in = rsp_ff;
      nwe = 1'b0; nwa = ncnt_ff[NumAw-1:0]; nwd = req_data.number_value;
      owe = 1'b0; owa = ocnt_ff[OprAw-1:0]; owd = opin_ff;
      nra = nm1[NumAw-1:0];
      ora = om1[OprAw-1:0];
      actl.start = 1'b0;
      actl.op = topop_ff;
      case (st_ff)
         S_IDLE: begin
            if (start && !busy) begin
               err_in = ERR_NONE;
               opin_in = req_data.operator_code;
               flush_in = (req_data.command == CMD_FLUSH);
               st_in = S_TOP;
               case (req_data.command)
                  CMD_PUSH: begin
                     if (ncnt_ff >= CntW'(NumDepth)) err_in = ERR_OVF;
                     else begin
                        nwe = 1'b1;
                        ncnt_in = ncnt_ff + CntW'(1);
                     end
                  end
                  CMD_OFFER, CMD_FLUSH: begin
                     st_in = S_RD;
                     ph_in = 2'd0;
                  end
                  default: ;
               endcase
            end
         end
         S_RD: begin
            // operator top read is issued; its data is registered in ord_ff for S_DEC
            st_in = S_DEC;
         end
         S_DEC: begin
            if (ocnt_ff == '0) begin
               // stack empty: stack offered operator unless close or flushing
               if (!flush_ff && opin_ff != OP_CLOSE) begin
                  if (ocnt_ff >= CntW'(OprDepth)) err_in = first_err(err_ff, ERR_OVF);
                  else begin
                     owe = 1'b1;
                     ocnt_in = ocnt_ff + CntW'(1);
                  end
               end
               st_in = S_TOP;
            end else if (flush_ff) begin
               ocnt_in = om1;
               if (ord_ff == OP_OPEN) st_in = S_TOP;
               else begin
                  topop_in = ord_ff;
                  st_in = S_ALU;
                  ph_in = 2'd0;
               end
            end else if (ord_ff == OP_OPEN) begin
               if (opin_ff == OP_CLOSE) ocnt_in = om1;
               else if (ocnt_ff >= CntW'(OprDepth)) err_in = first_err(err_ff, ERR_OVF);
               else begin
                  owe = 1'b1;
                  ocnt_in = ocnt_ff + CntW'(1);
               end
               st_in = S_TOP;
            end else if (prio(opin_ff) <= prio(ord_ff)) begin
               ocnt_in = om1;
               topop_in = ord_ff;
               st_in = S_ALU;
               ph_in = 2'd0;
            end else begin
               if (ocnt_ff >= CntW'(OprDepth)) err_in = first_err(err_ff, ERR_OVF);
               else begin
                  owe = 1'b1;
                  ocnt_in = ocnt_ff + CntW'(1);
               end
               st_in = S_TOP;
            end
         end
         S_ALU: begin
            // fetch operands: b at top, a below, then run the unit
            case (ph_ff)
               2'd0: begin
                  if (ncnt_ff < CntW'(2)) begin
                     err_in = first_err(err_ff, ERR_FEW);
                     st_in = S_RD;
                  end else begin
                     nra = nm1[NumAw-1:0];
                     ph_in = 2'd1;
                  end
               end
               2'd1: begin
                  rb_in = nrd_ff;
                  nra = nm2[NumAw-1:0];
                  ph_in = 2'd2;
               end
               2'd2: begin
                  ra_in = nrd_ff;
                  ph_in = 2'd3;
                  st_in = S_WB;
               end
               default: begin
                  st_in = S_WB;
               end
            endcase
         end
         S_WB: begin
            if (ph_ff == 2'd3) begin
               actl.start = 1'b1;
               ph_in = 2'd0;
            end else if (asts.done) begin
               if (asts.err != ERR_NONE) err_in = first_err(err_ff, asts.err);
               nwe = 1'b1;
               nwa = nm2[NumAw-1:0];
               nwd = ares;
               ncnt_in = nm1;
               st_in = S_RD;
            end
         end
         S_TOP: begin
            nra = nm1[NumAw-1:0];
            st_in = S_OUT;
         end
         default: begin
            rsp_in.top_value = (ncnt_ff == '0) ? 32'sd0 : nrd_ff;
            rsp_in.number_depth = ncnt_ff;
            rsp_in.operator_depth = ocnt_ff;
            rsp_in.error_code = err_ff;
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ncnt_ff <= '0;
         ocnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ncnt_ff <= ncnt_in;
         ocnt_ff <= ocnt_in;
         rsp_valid_ff <= (st_ff == S_OUT);
      end
      err_ff <= err_in;
      flush_ff <= flush_in;
      opin_ff <= opin_in;
      topop_ff <= topop_in;
      ra_ff <= ra_in;
      rb_ff <= rb_in;
      ph_ff <= ph_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (st_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `ASSERT_IMPLIES(a_ncnt_max, clock, reset, 1'b1, ncnt_ff <= CntW'(NumDepth), "number count over depth")
   `ASSERT_IMPLIES(a_ocnt_max, clock, reset, 1'b1, ocnt_ff <= CntW'(OprDepth), "operator count over depth")
   `ASSERT_NEXT(a_rsp_one, clock, reset, rsp_valid_ff, !rsp_valid_ff, "result strobe longer than one cycle")
   `ASSERT_IMPLIES(a_busy_rsp, clock, reset, rsp_valid_ff, busy, "result while not busy")
endmodule
